// File: hw/rtl/wpas_pkg.sv
`default_nettype none

package wpas_pkg;

    // Stream beat layout
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 112;

    // Field widths
    localparam int IDX_W   = 6;
    localparam int COORD_W = 32;
    localparam int DIST_W  = 33;
    localparam int COUNT_W = 7;
    localparam int RAD_W   = 32;
    localparam int DSQ_W   = 65;
    localparam int RSQ_W   = 64;

    // Input item kinds (s_tuser)
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_POS  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b1;

    // Partial product weights for the 16x16 multiplier
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_17 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;

    // Command to the multiply-accumulate unit
    typedef struct packed {
        logic        issue;
        logic        clr_dist;
        logic        clr_rad;
        logic        to_rad;
        logic [1:0]  shift_sel;
        logic [15:0] op_a;
        logic [15:0] op_b;
    } mac_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/waypoint_acceptance_sequencer_top.sv
`default_nettype none

// Waypoint acceptance sequencer. Load beats (s_tuser = 0) write one table entry
// and restart the mission at waypoint zero; position beats (s_tuser = 1) measure
// the distance to the active waypoint, advance to the next one when inside the
// switch radius, and return one result beat per input beat. One beat is worked
// at a time and s_tready is low meanwhile. A position update runs nine
// 16x16 partial products on the one shared multiplier to build the squared
// distance and the squared radius; a second pass of six products follows a
// switch, and the 33-step bit-serial square root gives the distance. A
// finished result waits in the output register until m_tready takes it.
// Table entries must be loaded before a position update reads them.
module waypoint_acceptance_sequencer_top #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [5:0] wp_index, [37:6] east_value, [69:38] north_value, [71:70] zero
    input  wire logic [wpas_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] kind
    input  wire logic                               s_tuser,
    // Output stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [32:0] distance, [33] switched, [34] mission_complete,
    // [40:35] active_index, [72:41] target_east, [104:73] target_north,
    // [111:105] zero
    output logic      [wpas_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [wpas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wpas_pkg::RAD_W-1:0]         cfg_data
);

    localparam int PW    = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W = ($clog2(MAX_WAYPOINTS + 1) > wpas_pkg::COUNT_W) ?
                           $clog2(MAX_WAYPOINTS + 1) : wpas_pkg::COUNT_W;
    localparam int CW    = wpas_pkg::COORD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_MAC  = 3'd3;
    localparam logic [2:0] S_MACW = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_SQRT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [3:0] STEP_RAD0 = 4'd0;
    localparam logic [3:0] STEP_DX0  = 4'd3;
    localparam logic [3:0] STEP_LAST = 4'd8;

    // Control state
    logic [2:0]                     state_reg,  state_next;
    logic [PW-1:0]                  ptr_reg,    ptr_next;
    logic [wpas_pkg::COUNT_W-1:0]   count_reg;
    logic [wpas_pkg::RAD_W-1:0]     radius_reg;
    logic [3:0]                     step_reg,   step_next;
    logic                           pass2_reg,  pass2_next;
    logic                           sw_reg,     sw_next;
    logic                           done_reg,   done_next;
    logic                           mvalid_reg, mvalid_next;

    // Payload
    logic                           kind_reg;
    logic [CW-1:0]                  se_reg;
    logic [CW-1:0]                  sn_reg;
    logic [CW-1:0]                  dx_reg,     dx_next;
    logic [CW-1:0]                  dy_reg,     dy_next;
    logic [wpas_pkg::M_TDATA_W-1:0] mdata_reg,  mdata_next;

    // Input fields
    logic [wpas_pkg::IDX_W-1:0]     in_idx;
    logic [CW-1:0]                  in_east;
    logic [CW-1:0]                  in_north;
    logic                           s_accept;

    // Table
    logic                           tbl_we;
    logic                           tbl_re;
    logic [2*CW-1:0]                tbl_rdata;
    logic [CW-1:0]                  ent_east;
    logic [CW-1:0]                  ent_north;

    // Arithmetic
    wpas_pkg::mac_cmd_t             mac_cmd;
    logic [wpas_pkg::DSQ_W-1:0]     dist_sq;
    logic [wpas_pkg::RSQ_W-1:0]     rad_sq;
    logic                           sq_start;
    logic                           sq_done;
    logic [wpas_pkg::DIST_W-1:0]    sq_root;

    logic [CNT_W-1:0]               cnt_raw;
    logic [CNT_W-1:0]               cnt_eff;
    logic [CNT_W-1:0]               ptr_inc;
    logic                           in_radius;
    logic signed [CW:0]             dex;
    logic signed [CW:0]             dnx;
    logic [CW:0]                    dex_mag;
    logic [CW:0]                    dnx_mag;
    logic [wpas_pkg::DIST_W-1:0]    dist_field;

    assign in_idx   = s_tdata[5:0];
    assign in_east  = s_tdata[37:6];
    assign in_north = s_tdata[69:38];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign ent_east  = tbl_rdata[CW-1:0];
    assign ent_north = tbl_rdata[2*CW-1:CW];

    // Table write on a load beat inside the table
    assign tbl_we = s_accept && (s_tuser == wpas_pkg::KIND_LOAD)
                    && (32'(in_idx) < 32'(MAX_WAYPOINTS));
    assign tbl_re = (state_reg == S_RD);

    wpas_table #(
        .DEPTH (MAX_WAYPOINTS),
        .AW    (PW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (PW'(in_idx)),
        .wdata ({in_north, in_east}),
        .re    (tbl_re),
        .raddr (ptr_reg),
        .rdata (tbl_rdata)
    );

    wpas_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mac_cmd),
        .dist_sq (dist_sq),
        .rad_sq  (rad_sq)
    );

    wpas_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (dist_sq),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Effective waypoint count, clamped to 1..MAX_WAYPOINTS
    always_comb
    begin
        cnt_raw = CNT_W'(count_reg);
        if (cnt_raw == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (cnt_raw > CNT_W'(MAX_WAYPOINTS))
        begin
            cnt_eff = CNT_W'(MAX_WAYPOINTS);
        end
        else
        begin
            cnt_eff = cnt_raw;
        end
        ptr_inc   = CNT_W'(ptr_reg) + CNT_W'(1);
        in_radius = (wpas_pkg::DSQ_W'(rad_sq) >= dist_sq);
    end

    // Coordinate differences, exact 33-bit, then magnitude
    always_comb
    begin
        dex     = $signed({ent_east[CW-1], ent_east}) - $signed({se_reg[CW-1], se_reg});
        dnx     = $signed({ent_north[CW-1], ent_north}) - $signed({sn_reg[CW-1], sn_reg});
        dex_mag = dex[CW] ? (CW+1)'(0) - dex : dex;
        dnx_mag = dnx[CW] ? (CW+1)'(0) - dnx : dnx;
    end

    // Multiplier operand schedule: radius (first pass only), then dx, then dy
    always_comb
    begin
        mac_cmd          = '0;
        mac_cmd.issue    = (state_reg == S_MAC);
        mac_cmd.clr_dist = (state_reg == S_RDW) && (kind_reg == wpas_pkg::KIND_POS);
        mac_cmd.clr_rad  = mac_cmd.clr_dist && !pass2_reg;
        case (step_reg)
            4'd0:
            begin
                mac_cmd.op_a = radius_reg[15:0];  mac_cmd.op_b = radius_reg[15:0];
                mac_cmd.shift_sel = wpas_pkg::SH_0;  mac_cmd.to_rad = 1'b1;
            end
            4'd1:
            begin
                mac_cmd.op_a = radius_reg[31:16]; mac_cmd.op_b = radius_reg[15:0];
                mac_cmd.shift_sel = wpas_pkg::SH_17; mac_cmd.to_rad = 1'b1;
            end
            4'd2:
            begin
                mac_cmd.op_a = radius_reg[31:16]; mac_cmd.op_b = radius_reg[31:16];
                mac_cmd.shift_sel = wpas_pkg::SH_32; mac_cmd.to_rad = 1'b1;
            end
            4'd3:
            begin
                mac_cmd.op_a = dx_reg[15:0];  mac_cmd.op_b = dx_reg[15:0];
                mac_cmd.shift_sel = wpas_pkg::SH_0;
            end
            4'd4:
            begin
                mac_cmd.op_a = dx_reg[31:16]; mac_cmd.op_b = dx_reg[15:0];
                mac_cmd.shift_sel = wpas_pkg::SH_17;
            end
            4'd5:
            begin
                mac_cmd.op_a = dx_reg[31:16]; mac_cmd.op_b = dx_reg[31:16];
                mac_cmd.shift_sel = wpas_pkg::SH_32;
            end
            4'd6:
            begin
                mac_cmd.op_a = dy_reg[15:0];  mac_cmd.op_b = dy_reg[15:0];
                mac_cmd.shift_sel = wpas_pkg::SH_0;
            end
            4'd7:
            begin
                mac_cmd.op_a = dy_reg[31:16]; mac_cmd.op_b = dy_reg[15:0];
                mac_cmd.shift_sel = wpas_pkg::SH_17;
            end
            4'd8:
            begin
                mac_cmd.op_a = dy_reg[31:16]; mac_cmd.op_b = dy_reg[31:16];
                mac_cmd.shift_sel = wpas_pkg::SH_32;
            end
            default:
            begin
                mac_cmd.op_a = '0; mac_cmd.op_b = '0;
                mac_cmd.shift_sel = wpas_pkg::SH_0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        step_next   = step_reg;
        pass2_next  = pass2_reg;
        sw_next     = sw_reg;
        done_next   = done_reg;
        mvalid_next = mvalid_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        mdata_next  = mdata_reg;
        sq_start    = 1'b0;
        dist_field  = (kind_reg == wpas_pkg::KIND_LOAD) ? '0 : sq_root;

        if (m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    sw_next    = 1'b0;
                    done_next  = 1'b0;
                    pass2_next = 1'b0;
                    if (s_tuser == wpas_pkg::KIND_LOAD)
                    begin
                        ptr_next = '0;
                    end
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                if (kind_reg == wpas_pkg::KIND_LOAD)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    dx_next    = dex_mag[CW-1:0];
                    dy_next    = dnx_mag[CW-1:0];
                    step_next  = pass2_reg ? STEP_DX0 : STEP_RAD0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_MACW;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_MACW:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!pass2_reg && in_radius && (ptr_inc < cnt_eff))
                begin
                    ptr_next   = ptr_reg + PW'(1);
                    sw_next    = 1'b1;
                    pass2_next = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    done_next  = (ptr_inc == cnt_eff) && in_radius;
                    sq_start   = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {7'd0, ent_north, ent_east,
                                   wpas_pkg::IDX_W'(ptr_reg), done_reg, sw_reg, dist_field};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ptr_reg    <= '0;
            step_reg   <= '0;
            pass2_reg  <= 1'b0;
            sw_reg     <= 1'b0;
            done_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            count_reg  <= wpas_pkg::COUNT_W'(1);
            radius_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            step_reg   <= step_next;
            pass2_reg  <= pass2_next;
            sw_reg     <= sw_next;
            done_reg   <= done_next;
            mvalid_reg <= mvalid_next;
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wpas_pkg::CFG_COUNT:  count_reg  <= cfg_data[wpas_pkg::COUNT_W-1:0];
                    wpas_pkg::CFG_RADIUS: radius_reg <= cfg_data;
                    default:              radius_reg <= radius_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg <= s_tuser;
            se_reg   <= in_east;
            sn_reg   <= in_north;
        end
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // A load beat restarts the mission at waypoint zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser == wpas_pkg::KIND_LOAD)) |=> (ptr_reg == '0))
        else $error("pointer not cleared by load beat");

    // The pointer stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(ptr_reg) < 32'(MAX_WAYPOINTS))
        else $error("pointer beyond table");

    // The pointer moves only by one step forward or back to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ptr_reg) |-> ((ptr_reg == $past(ptr_reg) + PW'(1)) || (ptr_reg == '0)))
        else $error("pointer jumped");

    // The root finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_SQRT))
        else $error("square root finished outside its wait state");

endmodule

`default_nettype wire

// File: hw/rtl/wpas_table.sv
`default_nettype none

// Waypoint table: one write port, one registered read port.
// Each word holds {north, east}.
module wpas_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [AW-1:0]                     waddr,
    input  wire logic [2*wpas_pkg::COORD_W-1:0]    wdata,
    input  wire logic                              re,
    input  wire logic [AW-1:0]                     raddr,
    output logic      [2*wpas_pkg::COORD_W-1:0]    rdata
);

    logic [2*wpas_pkg::COORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wpas_mac.sv
`default_nettype none

// Shared 16x16 multiplier with a weighted accumulator.
// Products are registered, then added into the distance or the radius sum.
module wpas_mac (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire wpas_pkg::mac_cmd_t             cmd,
    output logic      [wpas_pkg::DSQ_W-1:0]     dist_sq,
    output logic      [wpas_pkg::RSQ_W-1:0]     rad_sq
);

    logic                          pvalid_reg;
    logic [31:0]                   prod_reg;
    logic [1:0]                    psh_reg;
    logic                          pto_rad_reg;
    logic [wpas_pkg::DSQ_W-1:0]    dacc_reg;
    logic [wpas_pkg::RSQ_W-1:0]    racc_reg;
    logic [wpas_pkg::DSQ_W-1:0]    addend;
    logic [wpas_pkg::DSQ_W-1:0]    base;
    logic [wpas_pkg::DSQ_W-1:0]    sum;

    // Weight the registered product
    always_comb
    begin
        case (psh_reg)
            wpas_pkg::SH_0:  addend = wpas_pkg::DSQ_W'(prod_reg);
            wpas_pkg::SH_17: addend = wpas_pkg::DSQ_W'(prod_reg) << 17;
            wpas_pkg::SH_32: addend = wpas_pkg::DSQ_W'(prod_reg) << 32;
            default:         addend = '0;
        endcase
        base = pto_rad_reg ? wpas_pkg::DSQ_W'(racc_reg) : dacc_reg;
        sum  = base + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= cmd.issue;
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg    <= cmd.op_a * cmd.op_b;
        psh_reg     <= cmd.shift_sel;
        pto_rad_reg <= cmd.to_rad;
    end

    // Accumulate stage
    always_ff @(posedge clk)
    begin
        if (cmd.clr_dist)
        begin
            dacc_reg <= '0;
        end
        else if (pvalid_reg && !pto_rad_reg)
        begin
            dacc_reg <= sum;
        end

        if (cmd.clr_rad)
        begin
            racc_reg <= '0;
        end
        else if (pvalid_reg && pto_rad_reg)
        begin
            racc_reg <= sum[wpas_pkg::RSQ_W-1:0];
        end
    end

    assign dist_sq = dacc_reg;
    assign rad_sq  = racc_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wpas_isqrt.sv
`default_nettype none

// Bit-serial integer square root, two radicand bits per cycle.
// The root holds until the next start.
module wpas_isqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [wpas_pkg::DSQ_W-1:0]     radicand,
    output logic                                done,
    output logic      [wpas_pkg::DIST_W-1:0]    root
);

    localparam int RAD_PAD_W = wpas_pkg::DSQ_W + 1;
    localparam int REM_W     = wpas_pkg::DIST_W + 2;
    localparam int TRY_W     = REM_W + 2;

    logic                          busy_reg,  busy_next;
    logic                          done_reg,  done_next;
    logic [5:0]                    cnt_reg,   cnt_next;
    logic [RAD_PAD_W-1:0]          rad_reg,   rad_next;
    logic [REM_W-1:0]              rem_reg,   rem_next;
    logic [wpas_pkg::DIST_W-1:0]   root_reg,  root_next;
    logic [TRY_W-1:0]              shifted;
    logic [TRY_W-1:0]              trial;
    logic [TRY_W-1:0]              diff;

    // One restoring step
    always_comb
    begin
        shifted   = {rem_reg, rad_reg[RAD_PAD_W-1 -: 2]};
        trial     = TRY_W'({root_reg, 2'b01});
        diff      = shifted - trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = RAD_PAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (shifted >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[wpas_pkg::DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[REM_W-1:0];
                root_next = {root_reg[wpas_pkg::DIST_W-2:0], 1'b0};
            end
            if (cnt_reg == 6'(wpas_pkg::DIST_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: test/waypoint_acceptance_sequencer_top_tb.sv
module waypoint_acceptance_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = 64;
    localparam int RANDOM_BEATS   = 790;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;

    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;

    // One input beat, field by field
    typedef struct packed {
        logic        kind;
        logic [5:0]  wp_index;
        logic [31:0] east;
        logic [31:0] north;
    } nav_beat_t;

    // One result beat, laid out exactly as m_tdata (lowest field last)
    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] target_north;
        logic [31:0] target_east;
        logic [5:0]  active_index;
        logic        mission_complete;
        logic        switched;
        logic [32:0] distance;
    } nav_result_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [wpas_pkg::S_TDATA_W-1:0]    s_tdata   = '0;
    logic                              s_tuser   = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [wpas_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                              cfg_we    = 1'b0;
    logic [wpas_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [wpas_pkg::RAD_W-1:0]        cfg_data  = '0;

    waypoint_acceptance_sequencer_top #(
        .MAX_WAYPOINTS(TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Navigation state mirrored on the testbench side
    logic [31:0] wp_east  [TABLE_DEPTH];
    logic [31:0] wp_north [TABLE_DEPTH];
    bit          wp_loaded[TABLE_DEPTH];
    int          leg        = 0;
    logic [6:0]  count_reg  = 7'd1;
    logic [31:0] radius_reg = '0;

    nav_result_t pending_nav_results[$];
    int          nav_mismatches = 0;
    int          beats_sent     = 0;
    bit          tx_steady      = 1'b0;
    bit          rx_steady      = 1'b0;
    bit          rx_hold_req    = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Waypoint count with the clamp applied
    function automatic int active_span();
        if (count_reg == 7'd0)
            return 1;
        if (count_reg > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(count_reg);
    endfunction

    // Exact squared range from a table entry to a ship position (Q.16)
    function automatic logic [64:0] range_sq(int slot, logic [31:0] e, logic [31:0] n);
        logic signed [32:0] de;
        logic signed [32:0] dn;
        logic [64:0]        me;
        logic [64:0]        mn;
        de = $signed({wp_east[slot][31], wp_east[slot]}) - $signed({e[31], e});
        dn = $signed({wp_north[slot][31], wp_north[slot]}) - $signed({n[31], n});
        if (de < 0)
            de = -de;
        if (dn < 0)
            dn = -dn;
        me = {32'b0, de};
        mn = {32'b0, dn};
        return me * me + mn * mn;
    endfunction

    // Floor of the square root, one bit at a time from the top
    function automatic logic [32:0] floor_root(logic [64:0] sq);
        logic [32:0] root;
        logic [32:0] trial;
        logic [65:0] trial_sq;
        root = '0;
        for (int b = 32; b >= 0; b--)
        begin
            trial    = root | (33'd1 << b);
            trial_sq = {33'b0, trial} * {33'b0, trial};
            if (trial_sq <= {1'b0, sq})
                root = trial;
        end
        return root;
    endfunction

    // Apply one beat to the mirrored state and work out its result
    task automatic compute_nav_result(input nav_beat_t beat, output nav_result_t res);
        logic [64:0] dsq;
        logic [64:0] rsq;
        int          span;
        res  = '0;
        span = active_span();
        rsq  = {33'b0, radius_reg} * {33'b0, radius_reg};
        if (beat.kind == wpas_pkg::KIND_LOAD)
        begin
            wp_east[beat.wp_index]   = beat.east;
            wp_north[beat.wp_index]  = beat.north;
            wp_loaded[beat.wp_index] = 1'b1;
            leg = 0;
        end
        else
        begin
            dsq = range_sq(leg, beat.east, beat.north);
            // inside the radius with a leg left: advance and measure again
            if (dsq <= rsq && leg + 1 < span)
            begin
                leg++;
                dsq = range_sq(leg, beat.east, beat.north);
                res.switched = 1'b1;
            end
            res.distance         = floor_root(dsq);
            res.mission_complete = (leg + 1 == span) && (dsq <= rsq);
        end
        res.active_index = leg[5:0];
        res.target_east  = wp_east[leg];
        res.target_north = wp_north[leg];
    endtask

    // Offer one beat; returns at the falling edge after it was taken
    task automatic send_beat(input nav_beat_t beat);
        int          gap;
        nav_result_t res;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {2'b00, beat.north, beat.east, beat.wp_index};
        s_tuser  <= beat.kind;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        compute_nav_result(beat, res);
        pending_nav_results.push_back(res);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic load_wp(input int slot, input logic [31:0] e, input logic [31:0] n);
        nav_beat_t beat;
        beat.kind     = wpas_pkg::KIND_LOAD;
        beat.wp_index = slot[5:0];
        beat.east     = e;
        beat.north    = n;
        send_beat(beat);
    endtask

    // Position update; the index field is don't-care, so it carries noise
    task automatic fix_at(input logic [31:0] e, input logic [31:0] n);
        nav_beat_t beat;
        beat.kind     = wpas_pkg::KIND_POS;
        beat.wp_index = 6'($urandom_range(63));
        beat.east     = e;
        beat.north    = n;
        send_beat(beat);
    endtask

    task automatic write_reg(input logic [wpas_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == wpas_pkg::CFG_COUNT)
            count_reg = value[6:0];
        else
            radius_reg = value;
        @(negedge clk);
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_nav_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int bits);
        logic signed [31:0] v;
        v = $urandom;
        v = v <<< (32 - bits);
        return v >>> (32 - bits);
    endfunction

    function automatic int pick_scale();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return 12;
        if (roll < 55)
            return 18;
        if (roll < 75)
            return 24;
        if (roll < 88)
            return 28;
        return 32;
    endfunction

    function automatic logic [6:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 7'd0;
        if (roll < 15)
            return 7'd1;
        if (roll < 65)
            return 7'($urandom_range(6, 2));
        if (roll < 80)
            return 7'($urandom_range(63, 7));
        if (roll < 90)
            return 7'd64;
        return 7'($urandom_range(127, 65));
    endfunction

    function automatic logic [31:0] pick_radius();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 55)
            return $urandom_range(4095, 1);
        if (roll < 80)
            return $urandom_range(32'h0010_0000);
        if (roll < 90)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return C_MAX;
        if (v < -64'sh8000_0000)
            return C_MIN;
        return v[31:0];
    endfunction

    function automatic longint rand_off(longint half);
        return longint'($urandom_range(32'(2 * half))) - half;
    endfunction

    // A route plus a run of position fixes, mostly aimed at the active leg
    task automatic run_mission(input bit fresh, input int fixes, input int near_pct);
        int     span;
        int     bits;
        int     roll;
        longint half;
        longint reach;
        longint we;
        longint wn;
        span = active_span();
        bits = pick_scale();
        half = longint'(radius_reg) / 2;
        // slot zero goes first so no load ever reports an unwritten target
        for (int i = 0; i < span; i++)
            if ((fresh && i < 8) || !wp_loaded[i])
                load_wp(i, rand_coord(bits), rand_coord(bits));
        for (int k = 0; k < fixes; k++)
        begin
            we   = longint'($signed(wp_east[leg]));
            wn   = longint'($signed(wp_north[leg]));
            roll = $urandom_range(99);
            if (roll < near_pct)
                fix_at(sat32(we + rand_off(half)), sat32(wn + rand_off(half)));
            else
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        // on the radius along east, or one LSB past it
                        reach = longint'(radius_reg) + $urandom_range(1);
                        if ($urandom_range(1) != 0)
                            reach = -reach;
                        fix_at(sat32(we + reach), wp_north[leg]);
                    end
                    1:       fix_at(rand_coord(32), rand_coord(32));
                    default: load_wp($urandom_range(63), rand_coord(bits), rand_coord(bits));
                endcase
            end
        end
    endtask

    // Reset values of the registers, extreme coordinates, top table slot
    task automatic test_power_on_defaults();
        load_wp(0, 32'd0, 32'd0);
        fix_at(32'd0, 32'd0);
        fix_at(32'd256, 32'd0);
        load_wp(63, C_MAX, C_MIN);
        load_wp(0, C_MAX, C_MAX);
        fix_at(C_MIN, C_MIN);
        load_wp(0, C_MIN, C_MIN);
        fix_at(C_MAX, C_MAX);
        load_wp(0, C_MIN, C_MAX);
        fix_at(C_MAX, C_MIN);
    endtask

    // Leg advance, completion on the last leg, radius edge, reload restart
    task automatic test_leg_switching();
        wait_idle();
        write_reg(wpas_pkg::CFG_COUNT, 32'd3);
        write_reg(wpas_pkg::CFG_RADIUS, 32'd256);
        load_wp(0, 32'd1000, 32'd1000);
        load_wp(1, 32'd5000, -3000);
        load_wp(2, 32'd5000, -2900);
        fix_at(32'd1256, 32'd1000);
        fix_at(32'd5000, -3000);
        fix_at(32'd5000, -3000);
        fix_at(-40000, 32'd0);
        load_wp(1, 32'd5000, -3000);
        fix_at(32'd1257, 32'd1000);
        fix_at(32'd1181, 32'd1181);
    endtask

    // Count lowered under the active leg, count zero, widest radius
    task automatic test_count_limits();
        wait_idle();
        write_reg(wpas_pkg::CFG_COUNT, 32'd1);
        write_reg(wpas_pkg::CFG_RADIUS, 32'hFFFF_FFFF);
        fix_at(32'd5000, -3000);
        wait_idle();
        write_reg(wpas_pkg::CFG_COUNT, 32'd0);
        fix_at(32'd0, 32'd0);
        load_wp(0, C_MAX, C_MAX);
        fix_at(C_MAX - 32'd5, C_MAX);
        fix_at(C_MIN, C_MIN);
    endtask

    // Receiver holds off while beats keep coming, then the sender drains
    task automatic test_output_backpressure();
        wait_idle();
        write_reg(wpas_pkg::CFG_COUNT, 32'd5);
        write_reg(wpas_pkg::CFG_RADIUS, 32'h0000_4000);
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        run_mission(1'b1, 12, 90);
        tx_steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_missions();
        int          stop_at;
        int          span;
        bit          clean;
        logic [31:0] word;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at)
        begin
            wait_idle();
            tx_steady = ($urandom_range(5) == 0);
            rx_steady = ($urandom_range(5) == 0);
            if ($urandom_range(3) != 0)
            begin
                // upper data bits are noise for the count register
                word      = $urandom;
                word[6:0] = pick_count();
                write_reg(wpas_pkg::CFG_COUNT, word);
            end
            if ($urandom_range(3) != 0)
                write_reg(wpas_pkg::CFG_RADIUS, pick_radius());
            span  = active_span();
            clean = ($urandom_range(9) < 4);
            run_mission($urandom_range(3) != 0, $urandom_range(span + 8, 3), clean ? 95 : 70);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            nav_mismatches++;
            if (nav_mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $realtime, field, want, got);
        end
    endtask

    // Result beats against the oldest pending prediction
    always @(posedge clk)
    begin : result_check
        nav_result_t got;
        nav_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_nav_results.size() == 0)
            begin
                nav_mismatches++;
                if (nav_mismatches <= MAX_REPORTS)
                    $display("%0t: result beat with nothing pending, 0x%0h",
                             $realtime, m_tdata);
            end
            else
            begin
                want = pending_nav_results.pop_front();
                check_field("distance", want.distance, got.distance);
                check_field("switched", want.switched, got.switched);
                check_field("mission_complete", want.mission_complete,
                            got.mission_complete);
                check_field("active_index", want.active_index, got.active_index);
                check_field("target_east", want.target_east, got.target_east);
                check_field("target_north", want.target_north, got.target_north);
                check_field("padding", want.pad, got.pad);
            end
        end
    end

    // Output-side ready: random stalls, steady stretches, one long hold
    initial
    begin : rx_ready
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady)
                    stall = pick_gap();
            end
        end
    end

    // Ends a run that stops moving beats
    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("stalled with %0d result beats pending", pending_nav_results.size());
        $display("waypoint_acceptance_sequencer_top_tb: errors");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_power_on_defaults();
        test_leg_switching();
        test_count_limits();
        test_output_backpressure();
        test_random_missions();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (nav_mismatches == 0 && pending_nav_results.size() == 0)
            $display("waypoint_acceptance_sequencer_top_tb: clean");
        else
            $display("waypoint_acceptance_sequencer_top_tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/wpas_pkg.sv
hw/rtl/wpas_table.sv
hw/rtl/wpas_mac.sv
hw/rtl/wpas_isqrt.sv
hw/rtl/waypoint_acceptance_sequencer_top.sv
test/waypoint_acceptance_sequencer_top_tb.sv
